// ===== rtl/sbe_pkg.sv =====
// ---------------------------------------------------------------------------
// sbe_pkg
// Types, sizes and codes shared by the bytecode executor.
// ---------------------------------------------------------------------------
`default_nettype none
package sbe_pkg;
  localparam int STACK_DEPTH   = 64;
  localparam int VAR_DEPTH     = 64;
  localparam int SCOPE_DEPTH   = 16;
  localparam int PROGRAM_WORDS = 65536;
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int VA_W = $clog2(VAR_DEPTH);
  localparam int MA_W = $clog2(SCOPE_DEPTH);
  localparam int SC_W = SA_W + 1;
  localparam int VC_W = VA_W + 1;
  localparam int MC_W = MA_W + 1;

  typedef enum logic [4:0] {
    OP_PUSH = 5'd0, OP_ADDVAR = 5'd1, OP_PUSHVAR = 5'd2, OP_ADDSCOPE = 5'd3,
    OP_ENDSCOPE = 5'd4, OP_JMP_IF = 5'd5, OP_JMP = 5'd6, OP_EDIT = 5'd7,
    OP_ADD = 5'd8, OP_SUB = 5'd9, OP_MUL = 5'd10, OP_DIV = 5'd11,
    OP_EQ = 5'd12, OP_NEQ = 5'd13, OP_LESS = 5'd14, OP_LESS_EQ = 5'd15,
    OP_GREATER = 5'd16, OP_GREATER_EQ = 5'd17, OP_PRINT = 5'd18, OP_END = 5'd19
  } op_t;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_BAD_OP = 4'd1, ST_UNDER = 4'd2, ST_OVER = 4'd3,
    ST_BAD_VAR = 4'd4, ST_VAR_FULL = 4'd5, ST_SCOPE_UNDER = 4'd6,
    ST_SCOPE_OVER = 4'd7, ST_DIV0 = 4'd8, ST_BAD_JUMP = 4'd9, ST_HALTED = 4'd10
  } status_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] argument;
  } in_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        print_valid;
    logic [31:0] print_value;
    logic        halted;
    logic [3:0]  status;
  } out_item_t;
endpackage
`default_nettype wire

// ===== rtl/sbe_if.sv =====
// ---------------------------------------------------------------------------
// sbe_if
// Valid/ready channel that carries one item.
// ---------------------------------------------------------------------------
`default_nettype none
interface sbe_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbe_div.sv =====
// ---------------------------------------------------------------------------
// sbe_div
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module sbe_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem, quo, dvs;
  logic        neg;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      rem  <= '0;
      quo  <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs  <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg  <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (trial[32]) begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quotient = neg ? (32'd0 - quo) : quo;
endmodule
`default_nettype wire

// ===== rtl/stack_bytecode_executor.sv =====
// ---------------------------------------------------------------------------
// stack_bytecode_executor
// Executes one bytecode instruction per item on memory-held stacks.
// ---------------------------------------------------------------------------
// Each item passes through a memory read state (S_READ) and an execute
// state (S_EXEC); PUSHVAR, EDIT and binary operations other than DIV add
// the S_READ2 state, and DIV waits in S_DIV for the divider, which
// iterates one bit per cycle. One item is in work at a time, so a new item
// is taken only after the result of the last one has left on the output.
// Reset clears counters and the halt flag; memories are left as they are.
`default_nettype none
module stack_bytecode_executor (
  input wire logic clk,
  input wire logic rst,
  sbe_if.sink      in_ch,
  sbe_if.source    out_ch
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_READ2, S_EXEC, S_DIV, S_OUT} state_t;

  state_t state;
  logic [31:0] stk [sbe_pkg::STACK_DEPTH];
  logic [31:0] vars [sbe_pkg::VAR_DEPTH];
  logic [sbe_pkg::SC_W-1:0] marks [sbe_pkg::SCOPE_DEPTH];

  logic [15:0] pc;
  logic [sbe_pkg::SC_W-1:0] sc;
  logic [sbe_pkg::VC_W-1:0] vc;
  logic [sbe_pkg::MC_W-1:0] mc;
  logic stopped;
  logic [4:0]  kind;
  logic [31:0] arg;
  logic [31:0] rd_a, rd_b, rd_v;
  logic [sbe_pkg::SC_W-1:0] rd_m;
  sbe_pkg::out_item_t res;

  logic        div_start, div_done;
  logic [31:0] div_q;

  sbe_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(rd_a), .divisor(rd_b),
    .done(div_done), .quotient(div_q)
  );

  logic arg_var_ok, tgt_ok;
  assign arg_var_ok = !arg[31] && (arg < 32'(vc));
  assign tgt_ok = !arg[31] && (arg < 32'(sbe_pkg::PROGRAM_WORDS - 1));

  logic [sbe_pkg::SA_W-1:0] top_i, sec_i;
  assign top_i = sbe_pkg::SA_W'(sc - 1'b1);
  assign sec_i = sbe_pkg::SA_W'(sc - 2'd2);

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.payload = res;

  logic signed [31:0] sa, sb;
  logic [31:0] binres;
  assign sa = rd_a;
  assign sb = rd_b;
  always_comb begin
    unique case (kind)
      sbe_pkg::OP_ADD:     binres = rd_a + rd_b;
      sbe_pkg::OP_SUB:     binres = rd_a - rd_b;
      sbe_pkg::OP_MUL:     binres = rd_a * rd_b;
      sbe_pkg::OP_DIV:     binres = div_q;
      sbe_pkg::OP_EQ:      binres = {31'd0, sa == sb};
      sbe_pkg::OP_NEQ:     binres = {31'd0, sa != sb};
      sbe_pkg::OP_LESS:    binres = {31'd0, sa < sb};
      sbe_pkg::OP_LESS_EQ: binres = {31'd0, sa <= sb};
      sbe_pkg::OP_GREATER: binres = {31'd0, sa > sb};
      default:             binres = {31'd0, sa >= sb};
    endcase
  end

  logic is_bin;
  assign is_bin = kind >= sbe_pkg::OP_ADD && kind <= sbe_pkg::OP_GREATER_EQ;
  assign div_start = (state == S_EXEC) && kind == sbe_pkg::OP_DIV && !stopped
                     && sc >= 2 && rd_b != 0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pc      <= '0;
      sc      <= '0;
      vc      <= '0;
      mc      <= '0;
      stopped <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          kind  <= in_ch.payload.kind;
          arg   <= in_ch.payload.argument;
          state <= S_READ;
        end
        S_READ: begin
          rd_a <= stk[top_i];
          rd_b <= stk[sec_i];
          rd_v <= vars[arg[sbe_pkg::VA_W-1:0]];
          rd_m <= marks[sbe_pkg::MA_W'(mc - 1'b1)];
          state <= S_EXEC;
        end
        S_READ2: state <= S_OUT;
        S_DIV: if (div_done) begin
          stk[sec_i] <= binres;
          sc <= sc - 1'b1;
          pc <= pc + 16'd1;
          res.next_pc <= pc + 16'd1;
          state <= S_OUT;
        end
        S_EXEC: begin
          res.print_valid <= 1'b0;
          res.print_value <= '0;
          res.status <= sbe_pkg::ST_OK;
          res.halted <= stopped;
          res.next_pc <= pc;
          state <= S_OUT;
          if (stopped) begin
            res.status <= sbe_pkg::ST_HALTED;
          end else begin
            priority case (1'b1)
              kind == sbe_pkg::OP_PUSH: begin
                if (sc >= sbe_pkg::STACK_DEPTH) begin
                  res.status <= sbe_pkg::ST_OVER; stopped <= 1'b1; res.halted <= 1'b1;
                end else begin
                  stk[sbe_pkg::SA_W'(sc)] <= arg; sc <= sc + 1'b1;
                  pc <= pc + 16'd2; res.next_pc <= pc + 16'd2;
                end
              end
              kind == sbe_pkg::OP_ADDVAR: begin
                if (vc >= sbe_pkg::VAR_DEPTH) begin
                  res.status <= sbe_pkg::ST_VAR_FULL; stopped <= 1'b1; res.halted <= 1'b1;
                end else begin
                  vars[sbe_pkg::VA_W'(vc)] <= '0; vc <= vc + 1'b1;
                  pc <= pc + 16'd1; res.next_pc <= pc + 16'd1;
                end
              end
              kind == sbe_pkg::OP_PUSHVAR: begin
                if (!arg_var_ok) begin
                  res.status <= sbe_pkg::ST_BAD_VAR; stopped <= 1'b1; res.halted <= 1'b1;
                end else if (sc >= sbe_pkg::STACK_DEPTH) begin
                  res.status <= sbe_pkg::ST_OVER; stopped <= 1'b1; res.halted <= 1'b1;
                end else begin
                  stk[sbe_pkg::SA_W'(sc)] <= rd_v; sc <= sc + 1'b1;
                  pc <= pc + 16'd2; res.next_pc <= pc + 16'd2;
                  state <= S_READ2;
                end
              end
              kind == sbe_pkg::OP_ADDSCOPE: begin
                if (mc >= sbe_pkg::SCOPE_DEPTH) begin
                  res.status <= sbe_pkg::ST_SCOPE_OVER; stopped <= 1'b1; res.halted <= 1'b1;
                end else begin
                  marks[sbe_pkg::MA_W'(mc)] <= sc; mc <= mc + 1'b1;
                  pc <= pc + 16'd1; res.next_pc <= pc + 16'd1;
                end
              end
              kind == sbe_pkg::OP_ENDSCOPE: begin
                if (mc == 0) begin
                  res.status <= sbe_pkg::ST_SCOPE_UNDER; stopped <= 1'b1; res.halted <= 1'b1;
                end else begin
                  if (arg_var_ok) vc <= sbe_pkg::VC_W'(arg);
                  mc <= mc - 1'b1;
                  if (sc > rd_m) sc <= rd_m;
                  pc <= pc + 16'd2; res.next_pc <= pc + 16'd2;
                end
              end
              kind == sbe_pkg::OP_JMP_IF: begin
                if (sc == 0) begin
                  res.status <= sbe_pkg::ST_UNDER; stopped <= 1'b1; res.halted <= 1'b1;
                end else if (sa > 0) begin
                  stk[top_i] <= 32'd0;
                  pc <= pc + 16'd2; res.next_pc <= pc + 16'd2;
                end else if (!tgt_ok) begin
                  res.status <= sbe_pkg::ST_BAD_JUMP; stopped <= 1'b1; res.halted <= 1'b1;
                end else begin
                  stk[top_i] <= 32'd1;
                  pc <= arg[15:0] + 16'd1; res.next_pc <= arg[15:0] + 16'd1;
                end
              end
              kind == sbe_pkg::OP_JMP: begin
                if (!tgt_ok) begin
                  res.status <= sbe_pkg::ST_BAD_JUMP; stopped <= 1'b1; res.halted <= 1'b1;
                end else begin
                  pc <= arg[15:0] + 16'd1; res.next_pc <= arg[15:0] + 16'd1;
                end
              end
              kind == sbe_pkg::OP_EDIT: begin
                if (!arg_var_ok) begin
                  res.status <= sbe_pkg::ST_BAD_VAR; stopped <= 1'b1; res.halted <= 1'b1;
                end else if (sc == 0) begin
                  res.status <= sbe_pkg::ST_UNDER; stopped <= 1'b1; res.halted <= 1'b1;
                end else begin
                  vars[arg[sbe_pkg::VA_W-1:0]] <= rd_a; sc <= sc - 1'b1;
                  pc <= pc + 16'd2; res.next_pc <= pc + 16'd2;
                  state <= S_READ2;
                end
              end
              is_bin: begin
                if (sc < 2) begin
                  res.status <= sbe_pkg::ST_UNDER; stopped <= 1'b1; res.halted <= 1'b1;
                end else if (kind == sbe_pkg::OP_DIV && rd_b == 0) begin
                  res.status <= sbe_pkg::ST_DIV0; stopped <= 1'b1; res.halted <= 1'b1;
                end else if (kind == sbe_pkg::OP_DIV) begin
                  state <= S_DIV;
                end else begin
                  stk[sec_i] <= binres; sc <= sc - 1'b1;
                  pc <= pc + 16'd1; res.next_pc <= pc + 16'd1;
                  state <= S_READ2;
                end
              end
              kind == sbe_pkg::OP_PRINT: begin
                if (sc == 0) begin
                  res.status <= sbe_pkg::ST_UNDER; stopped <= 1'b1; res.halted <= 1'b1;
                end else begin
                  res.print_valid <= 1'b1; res.print_value <= rd_a;
                  pc <= pc + 16'd1; res.next_pc <= pc + 16'd1;
                end
              end
              kind == sbe_pkg::OP_END: begin
                stopped <= 1'b1; res.halted <= 1'b1;
              end
              default: begin
                res.status <= sbe_pkg::ST_BAD_OP; stopped <= 1'b1; res.halted <= 1'b1;
              end
            endcase
          end
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
